### rtl/c65_pkg.sv
package c65_pkg;

  localparam int unsigned AddrBits = 16;
  localparam int unsigned ByteBits = 8;
  localparam int unsigned WaitBits = 4;
  localparam int unsigned CmdBits = 2;
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned OutDataBits = 80;

  localparam logic [AddrBits-1:0] ResetVectorDefault = 16'h8000;
  localparam logic [WaitBits-1:0] ResetWaitDefault = 4'd7;
  localparam logic [ByteBits-1:0] SpPowerOn = 8'hFF;
  localparam logic [ByteBits-1:0] SpReset = 8'hFD;

  localparam logic [CfgIdxBits-1:0] CfgResetVector = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgResetWait = 1'b1;

  localparam logic [ByteBits-1:0] OpLdaImm = 8'hA9;
  localparam logic [ByteBits-1:0] OpLdxImm = 8'hA2;
  localparam logic [ByteBits-1:0] OpLdyImm = 8'hA0;
  localparam logic [ByteBits-1:0] OpLdaAbsX = 8'hBD;
  localparam logic [ByteBits-1:0] OpTax = 8'hAA;
  localparam logic [ByteBits-1:0] OpTay = 8'hA8;
  localparam logic [ByteBits-1:0] OpTxa = 8'h8A;
  localparam logic [ByteBits-1:0] OpTya = 8'h98;
  localparam logic [ByteBits-1:0] OpNop = 8'hEA;

  typedef enum logic [CmdBits-1:0] {
    CMD_CYCLE = 2'd0,
    CMD_RESET = 2'd1,
    CMD_POWER = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    PH_FETCH    = 3'd0,
    PH_OPER     = 3'd1,
    PH_HIGH     = 3'd2,
    PH_FIXUP    = 3'd3,
    PH_READ     = 3'd4,
    PH_INTERNAL = 3'd5,
    PH_WAIT     = 3'd6
  } phase_e;

  typedef struct packed {
    logic                bad_opcode;
    logic                instr_done;
    logic [ByteBits-1:0] sp_value;
    logic [AddrBits-1:0] pc_value;
    logic [ByteBits-1:0] status_byte;
    logic [ByteBits-1:0] y_value;
    logic [ByteBits-1:0] x_value;
    logic [ByteBits-1:0] acc_value;
    logic                bus_read;
    logic [AddrBits-1:0] bus_address;
  } result_t;

  localparam int unsigned ResultBits = $bits(result_t);

  function automatic logic [ByteBits-1:0] status_of(input logic n, input logic z);
    return {n, 1'b0, 1'b1, 2'b00, 1'b1, z, 1'b0};
  endfunction

endpackage

### rtl/c65_core.sv
module c65_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [c65_pkg::CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [c65_pkg::CfgDataBits-1:0] cfg_data_i,
  input  logic                       fire_i,
  input  c65_pkg::cmd_e              cmd_i,
  input  logic [c65_pkg::ByteBits-1:0] data_i,
  output c65_pkg::result_t           res_o
);
  import c65_pkg::*;

  logic [AddrBits-1:0] vec_q;
  logic [WaitBits-1:0] wcfg_q;

  logic [ByteBits-1:0] acc_q, acc_d, x_q, x_d, y_q, y_d, sp_q, sp_d, op_q, op_d;
  logic [AddrBits-1:0] pc_q, pc_d, base_q, base_d;
  logic                n_q, n_d, z_q, z_d;
  phase_e              phase_q, phase_d;
  logic [WaitBits-1:0] wait_q, wait_d;
  logic                done, bad;
  logic [ByteBits:0]   low_sum;
  logic [WaitBits-1:0] wait_dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q  <= ResetVectorDefault;
      wcfg_q <= ResetWaitDefault;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgResetVector: vec_q <= cfg_data_i[AddrBits-1:0];
        CfgResetWait:   wcfg_q <= cfg_data_i[WaitBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      pc_q    <= '0;
      sp_q    <= SpPowerOn;
      n_q     <= 1'b0;
      z_q     <= 1'b0;
      phase_q <= PH_FETCH;
      op_q    <= '0;
      base_q  <= '0;
      wait_q  <= '0;
    end else if (fire_i) begin
      acc_q   <= acc_d;
      x_q     <= x_d;
      y_q     <= y_d;
      pc_q    <= pc_d;
      sp_q    <= sp_d;
      n_q     <= n_d;
      z_q     <= z_d;
      phase_q <= phase_d;
      op_q    <= op_d;
      base_q  <= base_d;
      wait_q  <= wait_d;
    end
  end

  assign low_sum  = {1'b0, base_q[ByteBits-1:0]} + {1'b0, x_q};
  assign wait_dec = (wait_q != '0) ? wait_q - 1'b1 : '0;

  always_comb begin
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    pc_d    = pc_q;
    sp_d    = sp_q;
    n_d     = n_q;
    z_d     = z_q;
    phase_d = phase_q;
    op_d    = op_q;
    base_d  = base_q;
    wait_d  = wait_q;
    done    = 1'b0;
    bad     = 1'b0;
    case (cmd_i)
      CMD_CYCLE: begin
        case (phase_q)
          PH_FETCH: begin
            op_d = data_i;
            pc_d = pc_q + 1'b1;
            if (data_i inside {OpLdaImm, OpLdxImm, OpLdyImm, OpLdaAbsX}) begin
              phase_d = PH_OPER;
            end else begin
              phase_d = PH_INTERNAL;
            end
          end
          PH_OPER: begin
            pc_d = pc_q + 1'b1;
            if (op_q == OpLdaAbsX) begin
              base_d  = {{(AddrBits-ByteBits){1'b0}}, data_i};
              phase_d = PH_HIGH;
            end else begin
              case (op_q)
                OpLdxImm: x_d = data_i;
                OpLdyImm: y_d = data_i;
                default:  acc_d = data_i;
              endcase
              n_d     = data_i[ByteBits-1];
              z_d     = (data_i == '0);
              phase_d = PH_FETCH;
              done    = 1'b1;
            end
          end
          PH_HIGH: begin
            pc_d    = pc_q + 1'b1;
            base_d  = {data_i, base_q[ByteBits-1:0]};
            phase_d = low_sum[ByteBits] ? PH_FIXUP : PH_READ;
          end
          PH_FIXUP: phase_d = PH_READ;
          PH_READ: begin
            acc_d   = data_i;
            n_d     = data_i[ByteBits-1];
            z_d     = (data_i == '0);
            phase_d = PH_FETCH;
            done    = 1'b1;
          end
          PH_INTERNAL: begin
            case (op_q)
              OpTax: begin
                x_d = acc_q;
                n_d = acc_q[ByteBits-1];
                z_d = (acc_q == '0);
              end
              OpTay: begin
                y_d = acc_q;
                n_d = acc_q[ByteBits-1];
                z_d = (acc_q == '0);
              end
              OpTxa: begin
                acc_d = x_q;
                n_d   = x_q[ByteBits-1];
                z_d   = (x_q == '0);
              end
              OpTya: begin
                acc_d = y_q;
                n_d   = y_q[ByteBits-1];
                z_d   = (y_q == '0);
              end
              OpNop: ;
              default: bad = 1'b1;
            endcase
            phase_d = PH_FETCH;
            done    = 1'b1;
          end
          PH_WAIT: begin
            wait_d = wait_dec;
            if (wait_dec == '0) begin
              phase_d = PH_FETCH;
            end
          end
          default: phase_d = PH_FETCH;
        endcase
      end
      CMD_RESET: begin
        acc_d   = '0;
        x_d     = '0;
        y_d     = '0;
        pc_d    = vec_q;
        sp_d    = SpReset;
        n_d     = 1'b0;
        z_d     = 1'b0;
        op_d    = '0;
        base_d  = '0;
        wait_d  = wcfg_q;
        phase_d = (wcfg_q != '0) ? PH_WAIT : PH_FETCH;
      end
      CMD_POWER: begin
        acc_d   = '0;
        x_d     = '0;
        y_d     = '0;
        pc_d    = '0;
        sp_d    = SpPowerOn;
        n_d     = 1'b0;
        z_d     = 1'b0;
        op_d    = '0;
        base_d  = '0;
        wait_d  = '0;
        phase_d = PH_FETCH;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.bus_address = (phase_d == PH_READ) ?
                        base_d + {{(AddrBits-ByteBits){1'b0}}, x_d} : pc_d;
    res_o.bus_read    = phase_d inside {PH_FETCH, PH_OPER, PH_HIGH, PH_READ};
    res_o.acc_value   = acc_d;
    res_o.x_value     = x_d;
    res_o.y_value     = y_d;
    res_o.status_byte = status_of(n_d, z_d);
    res_o.pc_value    = pc_d;
    res_o.sp_value    = sp_d;
    res_o.instr_done  = done;
    res_o.bad_opcode  = bad;
  end

  a_wait_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT) |-> (wait_q != '0))
    else $error("wait phase entered with an empty wait count");

  a_fixup_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && cmd_i == CMD_CYCLE && phase_q == PH_FIXUP) |=> (phase_q == PH_READ))
    else $error("page fixup cycle not followed by the data read");

  a_bad_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.bad_opcode |-> (res_o.instr_done && phase_q == PH_INTERNAL))
    else $error("bad opcode flagged outside an instruction completion");

endmodule

### rtl/c65_skid.sv
module c65_skid (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  c65_pkg::result_t      in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output c65_pkg::result_t      out_data_o
);
  import c65_pkg::*;

  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  result_t out_q, out_d, skid_q, skid_d;
  logic    in_fire;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = in_data_i;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = in_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while the output stage is empty");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i && in_valid_i))
    else $error("skid entry filled without a stalled output");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid entry not moved to the output stage");

endmodule

### rtl/cpu6502_subset_cycle_core.sv
// Channel   Dir  Payload                                    Transfer
// s_axis    in   tuser: command; tdata: read_data           tvalid & tready
// m_axis    out  tdata: one bus-cycle result (see port)     tvalid & tready
// cfg       in   index 0 reset_vector, 1 reset_wait_cycles  cfg_we_i
//
// Each input transfer is one bus cycle or event; the output stage registers its result.
// A new transfer is taken every cycle while the skid is empty; the output stage plus a
// one-entry skid buffer takes a transfer in an output stall, then s_axis_tready drops.
// Reset clears the CPU to its power-on state and loads the register defaults.
module cpu6502_subset_cycle_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [c65_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [c65_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [c65_pkg::ByteBits-1:0]       s_axis_tdata,  // read_data
  input  logic [c65_pkg::CmdBits-1:0]        s_axis_tuser,  // command
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // bus_address, bus_read, acc_value, x_value, y_value, status_byte, pc_value,
  // sp_value, instr_done, bad_opcode, zero fill
  output logic [c65_pkg::OutDataBits-1:0]    m_axis_tdata
);
  import c65_pkg::*;

  result_t core_res, out_res;
  logic    fire;

  assign fire = s_axis_tvalid && s_axis_tready;

  c65_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (fire),
    .cmd_i      (cmd_e'(s_axis_tuser)),
    .data_i     (s_axis_tdata),
    .res_o      (core_res)
  );

  c65_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (core_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res)
  );

  assign m_axis_tdata = {{(OutDataBits-ResultBits){1'b0}}, out_res};

endmodule
